// ===== rtl/core/sha1_pkg.sv =====
// Package for the SHA-1 hash block: item types, queue entry, state enums and constants.
// Used by every module under rtl/core; depends on nothing.
package sha1_pkg;

  localparam int SHA1_QUEUE_DEPTH = 4;

  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  localparam logic [7:0] SHA1_PAD_BYTE = 8'h80;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;
    logic        final_blk;
    logic        ovf;
  } q_entry_t;

  typedef enum logic {
    F_DATA,
    F_PAD
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_FINAL
  } back_state_t;

endpackage

// ===== rtl/core/sha1_hash_top.sv =====
// Top level of the SHA-1 hash block: front end, word queue and compression engine.
// Depends on sha1_pkg, sha1_front, sha1_queue and sha1_back.
//
// Usage: items enter through a queue-style port. An item is taken at a clock edge with
// push high and full low. A data item (kind 0) adds one message byte; a finish item
// (kind 1) pads the message and yields five digest words, word 0 first, the fifth with
// last_word set. Results leave through a queue-style port: the oldest word is on out_item
// while empty is low and is taken at an edge with pop high.
// Bytes are taken at most one per cycle while full is low and packed into words that a
// short queue (four words by default) carries to the compression engine. The engine
// loads the 16 words of a block, runs 80 rounds (one round per cycle) and then does the
// chaining update. The front end stalls once the queue fills during the rounds.
// A finish transaction pushes up to 18 padding words; the first digest word shows after
// the last padded block is compressed, which takes an extra block when the length does
// not fit in the current one, later still if earlier blocks are still in flight.
// While the digest waits to be taken, the next message is gathered and its blocks are
// compressed; only the next digest waits for the output to drain.
// The synchronous reset rst_n clears all control state and loads the initial chaining
// values; no clearing pass follows.
module sha1_hash_top
  import sha1_pkg::*;
#(
  parameter int QUEUE_DEPTH = SHA1_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_wr_entry, q_rd_entry;

  sha1_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr_entry)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  sha1_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ===== rtl/core/sha1_front.sv =====
// SHA-1 front end: takes message bytes and finish commands, packs words, pads the message.
// Depends on sha1_pkg; feeds sha1_queue.
module sha1_front
  import sha1_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_entry
);

  front_state_t state_r, state_nxt;
  logic [23:0]  acc_r, acc_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         ovf_r, ovf_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic         first_r, first_nxt;
  logic         len_blk_r, len_blk_nxt;
  logic [31:0]  pad_first;
  logic         accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_DATA;
      fill_r    <= '0;
      bits_r    <= '0;
      ovf_r     <= 1'b0;
      pos_r     <= '0;
      first_r   <= 1'b0;
      len_blk_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      bits_r    <= bits_nxt;
      ovf_r     <= ovf_nxt;
      pos_r     <= pos_nxt;
      first_r   <= first_nxt;
      len_blk_r <= len_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_comb begin
    case (fill_r[1:0])
      2'd0:    pad_first = {SHA1_PAD_BYTE, 24'd0};
      2'd1:    pad_first = {acc_r[7:0], SHA1_PAD_BYTE, 16'd0};
      2'd2:    pad_first = {acc_r[15:0], SHA1_PAD_BYTE, 8'd0};
      default: pad_first = {acc_r, SHA1_PAD_BYTE};
    endcase
  end

  assign full   = (state_r != F_DATA) || q_full;
  assign accept = push && !full;

  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    fill_nxt    = fill_r;
    bits_nxt    = bits_r;
    ovf_nxt     = ovf_r;
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    len_blk_nxt = len_blk_r;
    q_push      = 1'b0;
    q_entry     = '{word: {acc_r, in_item.data_byte}, blk_end: (fill_r == 6'd63),
                    final_blk: 1'b0, ovf: ovf_r};
    case (state_r)
      F_DATA: begin
        if (accept && in_item.kind == KIND_DATA) begin
          if (&bits_r[63:3]) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt  = {acc_r[15:0], in_item.data_byte};
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
            q_push   = (fill_r[1:0] == 2'd3);
          end
        end else if (accept && in_item.kind == KIND_FINISH) begin
          state_nxt   = F_PAD;
          pos_nxt     = fill_r[5:2];
          first_nxt   = 1'b1;
          len_blk_nxt = (fill_r[5:3] != 3'b111);
        end
      end
      F_PAD: begin
        if (first_r) begin
          q_entry.word = pad_first;
        end else if (len_blk_r && pos_r == 4'd14) begin
          q_entry.word = bits_r[63:32];
        end else if (len_blk_r && pos_r == 4'd15) begin
          q_entry.word = bits_r[31:0];
        end else begin
          q_entry.word = '0;
        end
        q_entry.blk_end   = (pos_r == 4'd15);
        q_entry.final_blk = len_blk_r && (pos_r == 4'd15);
        if (!q_full) begin
          q_push    = 1'b1;
          pos_nxt   = pos_r + 4'd1;
          first_nxt = 1'b0;
          if (pos_r == 4'd15) begin
            if (len_blk_r) begin
              state_nxt = F_DATA;
              fill_nxt  = '0;
              bits_nxt  = '0;
              ovf_nxt   = 1'b0;
            end else begin
              len_blk_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = F_DATA;
    endcase
  end

endmodule

// ===== rtl/core/sha1_queue.sv =====
// Short word queue between the SHA-1 front end and the compression engine.
// Depends on sha1_pkg for the entry type.
module sha1_queue
  import sha1_pkg::*;
#(
  parameter int DEPTH = SHA1_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  q_entry_t wr_entry,
  output logic     full,
  input  logic     rd_en,
  output q_entry_t rd_entry,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !empty;
  assign rd_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ===== rtl/core/sha1_back.sv =====
// SHA-1 compression engine: loads 16 block words, runs 80 rounds, holds the digest for output.
// Depends on sha1_pkg; fed by sha1_queue.
module sha1_back
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;
  logic [31:0] hash_r [5];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  round_r;
  logic        fin_r, ovf_r;
  logic [31:0] out_words_r [5];
  logic [2:0]  out_idx_r;
  logic        out_busy_r, out_ovf_r;
  logic [31:0] f_val, k_val, t_val, w_new;
  logic [31:0] sum [5];

  assign q_pop = (state_r == B_LOAD) && !q_empty;
  assign empty = !out_busy_r;

  assign out_item = '{digest_word: out_words_r[0], word_index: out_idx_r,
                      last_word: (out_idx_r == 3'd4), overflow: out_ovf_r};

  always_comb begin
    if (round_r < 7'd20) begin
      f_val = d_r ^ (b_r & (c_r ^ d_r));
      k_val = SHA1_K0;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = SHA1_K1;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (d_r & (b_r | c_r));
      k_val = SHA1_K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = SHA1_K3;
    end
    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + w_r[0] + k_val;
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
    sum[0] = hash_r[0] + a_r;
    sum[1] = hash_r[1] + b_r;
    sum[2] = hash_r[2] + c_r;
    sum[3] = hash_r[3] + d_r;
    sum[4] = hash_r[4] + e_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_LOAD: begin
        if (q_pop && q_entry.blk_end) begin
          state_nxt = B_ROUND;
        end
      end
      B_ROUND: begin
        if (round_r == 7'd79) begin
          state_nxt = B_FINAL;
        end
      end
      B_FINAL: begin
        if (!fin_r || !out_busy_r) begin
          state_nxt = B_LOAD;
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_LOAD;
      out_busy_r <= 1'b0;
      out_idx_r  <= '0;
      round_r    <= '0;
      fin_r      <= 1'b0;
      ovf_r      <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        hash_r[i] <= SHA1_IV[i];
      end
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_entry.blk_end) begin
        fin_r   <= q_entry.final_blk;
        ovf_r   <= q_entry.ovf;
        round_r <= '0;
      end else if (state_r == B_ROUND) begin
        round_r <= round_r + 7'd1;
      end
      if (pop && out_busy_r) begin
        out_idx_r <= out_idx_r + 3'd1;
        if (out_idx_r == 3'd4) begin
          out_busy_r <= 1'b0;
        end
      end
      if (state_r == B_FINAL) begin
        if (!fin_r) begin
          for (int i = 0; i < 5; i++) begin
            hash_r[i] <= sum[i];
          end
        end else if (!out_busy_r) begin
          for (int i = 0; i < 5; i++) begin
            hash_r[i] <= SHA1_IV[i];
          end
          out_busy_r <= 1'b1;
          out_idx_r  <= '0;
          out_ovf_r  <= ovf_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= q_entry.word;
      a_r     <= hash_r[0];
      b_r     <= hash_r[1];
      c_r     <= hash_r[2];
      d_r     <= hash_r[3];
      e_r     <= hash_r[4];
    end else if (state_r == B_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      a_r     <= t_val;
      b_r     <= a_r;
      c_r     <= {b_r[1:0], b_r[31:2]};
      d_r     <= c_r;
      e_r     <= d_r;
    end
    if (state_r == B_FINAL && fin_r && !out_busy_r) begin
      for (int i = 0; i < 5; i++) begin
        out_words_r[i] <= sum[i];
      end
    end else if (pop && out_busy_r) begin
      for (int i = 0; i < 4; i++) begin
        out_words_r[i] <= out_words_r[i+1];
      end
    end
  end

endmodule
